// ----- hdl/pps_pkg.sv -----
package pps_pkg;

  // chain size and datapath width
  localparam int NUM_STAGES  = 16;
  localparam int VALUE_WIDTH = 16;

  // counter widths
  localparam int DCNT_W = $clog2(VALUE_WIDTH);
  localparam int KCNT_W = $clog2(NUM_STAGES + 1);

  // result kind codes
  localparam logic [1:0] KIND_PRIME    = 2'd0;
  localparam logic [1:0] KIND_SURVIVOR = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;

  // input transaction
  typedef struct packed {
    logic [15:0] number;
    logic        end_of_run;
  } in_item_t;

  // output transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic [3:0]  stage_index;
  } out_item_t;

  // broadcast control from sequencer to every cell
  typedef struct packed {
    logic clear;
    logic div_clr;
    logic div_step;
    logic nbit;
  } cell_ctl_t;

  // per-cell status
  typedef struct packed {
    logic hit;
    logic drop;
    logic filled;
  } cell_stat_t;

  // combined chain status seen by the sequencer
  typedef struct packed {
    logic hit;
    logic drop;
    logic last_pass;
  } scan_stat_t;

endpackage

// ----- hdl/pipelined_prime_sieve.sv -----
// number transaction: remainder steps over all VALUE_WIDTH dividend bits run in every cell at once,
// then a token walks the cell chain one cell per cycle; a prime captured by cell k or a
// survivor (k = NUM_STAGES) is then loaded into the output register, or parked while the output stalls
// end-of-run transaction: result registered (or parked while the output stalls), all cells cleared
// one transaction in flight; the next is taken once the previous result is registered or the number is dropped
// reset (rst_n low, synchronous): all cells empty, no result pending
module pipelined_prime_sieve (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  pps_pkg::in_item_t   in_data,
  output logic                in_stall,
  output logic                out_valid,
  output pps_pkg::out_item_t  out_data,
  input  logic                out_stall
);

  pps_pkg::cell_ctl_t              ctl;
  logic [pps_pkg::VALUE_WIDTH-1:0] cand;
  logic                            start;
  pps_pkg::scan_stat_t             stat;
  logic [pps_pkg::NUM_STAGES:0]    pass_chain;
  pps_pkg::cell_stat_t             cell_stat [pps_pkg::NUM_STAGES];
  logic [pps_pkg::NUM_STAGES-1:0]  hit_v;
  logic [pps_pkg::NUM_STAGES-1:0]  drop_v;
  logic [pps_pkg::NUM_STAGES-1:0]  filled_v;

  // sequencer
  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .ctl       (ctl),
    .cand      (cand),
    .start     (start),
    .stat      (stat)
  );

  assign pass_chain[0] = start;

  // sieve cell chain
  for (genvar i = 0; i < pps_pkg::NUM_STAGES; i++) begin : g_cell
    pps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .cand     (cand),
      .pass_in  (pass_chain[i]),
      .pass_out (pass_chain[i+1]),
      .stat     (cell_stat[i])
    );
    assign hit_v[i]    = cell_stat[i].hit;
    assign drop_v[i]   = cell_stat[i].drop;
    assign filled_v[i] = cell_stat[i].filled;
  end

  // chain status
  assign stat.hit       = |hit_v;
  assign stat.drop      = |drop_v;
  assign stat.last_pass = pass_chain[pps_pkg::NUM_STAGES];

  // at most one cell acts on the token
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_v | drop_v))
    else $error("more than one cell acted in one cycle");

  // cells only act while a number transaction is in progress
  a_event_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ((hit_v | drop_v) != '0) |-> in_stall)
    else $error("cell event while idle");

  // end of run empties the whole chain
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.end_of_run) |=> (filled_v == '0))
    else $error("cells not cleared after end of run");

endmodule

// ----- hdl/pps_cell.sv -----
module pps_cell (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pps_pkg::cell_ctl_t                     ctl,
  input  logic [pps_pkg::VALUE_WIDTH-1:0]        cand,
  input  logic                                   pass_in,
  output logic                                   pass_out,
  output pps_pkg::cell_stat_t                    stat
);

  logic                            filled_r, filled_nxt;
  logic                            pass_r, pass_nxt;
  logic [pps_pkg::VALUE_WIDTH-1:0] prime_r, prime_nxt;
  logic [pps_pkg::VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [pps_pkg::VALUE_WIDTH:0]   ext;
  logic [pps_pkg::VALUE_WIDTH:0]   ext_sub;
  logic                            divides;

  // one restoring division step per cycle, dividend bit broadcast msb first
  always_comb begin
    ext     = {rem_r, ctl.nbit};
    ext_sub = ext - {1'b0, prime_r};
    if (ctl.div_clr) begin
      rem_nxt = '0;
    end else if (ctl.div_step) begin
      rem_nxt = (ext >= {1'b0, prime_r}) ? ext_sub[pps_pkg::VALUE_WIDTH-1:0]
                                         : ext[pps_pkg::VALUE_WIDTH-1:0];
    end else begin
      rem_nxt = rem_r;
    end
  end

  // a zero prime never divides
  assign divides = (prime_r != '0) && (rem_r == '0);

  // token handling: capture when empty, drop on divide, else hand on
  always_comb begin
    stat.hit    = pass_in && !filled_r;
    stat.drop   = pass_in && filled_r && divides;
    stat.filled = filled_r;
    pass_nxt    = pass_in && filled_r && !divides;
    prime_nxt   = stat.hit ? cand : prime_r;
    if (ctl.clear) begin
      filled_nxt = 1'b0;
    end else if (stat.hit) begin
      filled_nxt = 1'b1;
    end else begin
      filled_nxt = filled_r;
    end
  end

  assign pass_out = pass_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= 1'b0;
      pass_r   <= 1'b0;
    end else begin
      filled_r <= filled_nxt;
      pass_r   <= pass_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    prime_r <= prime_nxt;
    rem_r   <= rem_nxt;
  end

endmodule

// ----- hdl/pps_ctrl.sv -----
module pps_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  pps_pkg::in_item_t               in_data,
  output logic                            in_stall,
  output logic                            out_valid,
  output pps_pkg::out_item_t              out_data,
  input  logic                            out_stall,
  output pps_pkg::cell_ctl_t              ctl,
  output logic [pps_pkg::VALUE_WIDTH-1:0] cand,
  output logic                            start,
  input  pps_pkg::scan_stat_t             stat
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_PEND
  } state_t;

  state_t                          state_r, state_nxt;
  logic [pps_pkg::VALUE_WIDTH-1:0] num_r, num_nxt;
  logic [pps_pkg::VALUE_WIDTH-1:0] sh_r, sh_nxt;
  logic [pps_pkg::DCNT_W-1:0]      dcnt_r, dcnt_nxt;
  logic [pps_pkg::KCNT_W-1:0]      kcnt_r, kcnt_nxt;
  pps_pkg::out_item_t              res_r, res_nxt;
  logic                            out_valid_r, out_valid_nxt;
  pps_pkg::out_item_t              out_data_r, out_data_nxt;
  logic                            have_res;
  pps_pkg::out_item_t              res;
  logic                            out_free;

  assign out_free = !out_valid_r || !out_stall;

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    sh_nxt        = sh_r;
    dcnt_nxt      = dcnt_r;
    kcnt_nxt      = kcnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    start         = 1'b0;
    have_res      = 1'b0;
    res           = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.end_of_run) begin
            ctl.clear = 1'b1;
            have_res  = 1'b1;
            res.kind  = pps_pkg::KIND_END;
          end else begin
            num_nxt     = pps_pkg::VALUE_WIDTH'(in_data.number);
            sh_nxt      = pps_pkg::VALUE_WIDTH'(in_data.number);
            ctl.div_clr = 1'b1;
            dcnt_nxt    = '0;
            state_nxt   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        ctl.nbit     = sh_r[pps_pkg::VALUE_WIDTH-1];
        sh_nxt       = sh_r << 1;
        dcnt_nxt     = dcnt_r + 1'b1;
        if (dcnt_r == pps_pkg::DCNT_W'(pps_pkg::VALUE_WIDTH - 1)) begin
          kcnt_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        start = (kcnt_r == '0);
        priority if (stat.hit) begin
          have_res        = 1'b1;
          res.kind        = pps_pkg::KIND_PRIME;
          res.value       = 16'(num_r);
          res.stage_index = 4'(kcnt_r);
        end else if (stat.drop) begin
          state_nxt = ST_IDLE;
        end else if (stat.last_pass) begin
          have_res  = 1'b1;
          res.kind  = pps_pkg::KIND_SURVIVOR;
          res.value = 16'(num_r);
        end else begin
          // token still walking the chain
          kcnt_nxt = kcnt_r + 1'b1;
        end
      end
      ST_PEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // hand a finished result to the output register, or park it
    if (have_res) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
        state_nxt     = ST_IDLE;
      end else begin
        res_nxt   = res;
        state_nxt = ST_PEND;
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r      <= num_nxt;
    sh_r       <= sh_nxt;
    dcnt_r     <= dcnt_nxt;
    kcnt_r     <= kcnt_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cand      = num_r;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;

  // run limits
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = pps_pkg::VALUE_WIDTH + pps_pkg::NUM_STAGES + 8;
  localparam int RANDOM_ITEMS  = 480;
  localparam int QUIET_TAIL    = 100;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  pps_pkg::in_item_t  in_data;
  logic               in_stall;
  logic               out_valid;
  pps_pkg::out_item_t out_data;
  logic               out_stall;

  // sieve state as the chain should hold it
  logic [pps_pkg::VALUE_WIDTH-1:0] sieve_prime [pps_pkg::NUM_STAGES];
  logic                            sieve_full  [pps_pkg::NUM_STAGES];

  pps_pkg::out_item_t pending_reports[$];
  int                 fail_count;
  int                 sent_items;
  int                 cycle_count;
  bit                 quiet;

  pipelined_prime_sieve i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // walk one number through the sieve, returns 1 when it yields a report
  function automatic bit predict_sieve(input pps_pkg::in_item_t item,
                                       output pps_pkg::out_item_t rep);
    logic [pps_pkg::VALUE_WIDTH-1:0] n;
    n = pps_pkg::VALUE_WIDTH'(item.number);
    rep = '0;
    if (item.end_of_run) begin
      for (int s = 0; s < pps_pkg::NUM_STAGES; s++) begin
        sieve_prime[s] = '0;
        sieve_full[s]  = 1'b0;
      end
      rep.kind = pps_pkg::KIND_END;
      return 1'b1;
    end
    for (int s = 0; s < pps_pkg::NUM_STAGES; s++) begin
      // empty stage takes the number as its prime
      if (!sieve_full[s]) begin
        sieve_full[s]    = 1'b1;
        sieve_prime[s]   = n;
        rep.kind         = pps_pkg::KIND_PRIME;
        rep.value        = 16'(n);
        rep.stage_index  = 4'(s);
        return 1'b1;
      end
      // a zero prime never divides
      if (sieve_prime[s] != '0 && (n % sieve_prime[s]) == '0)
        return 1'b0;
    end
    rep.kind  = pps_pkg::KIND_SURVIVOR;
    rep.value = 16'(n);
    return 1'b1;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // send one transaction, predict its report once accepted
  task automatic send_item(input logic [15:0] num, input logic eor);
    pps_pkg::in_item_t  item;
    pps_pkg::out_item_t rep;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item.number     = num;
    item.end_of_run = eor;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sent_items++;
    if (predict_sieve(item, rep))
      pending_reports.push_back(rep);
  endtask

  task automatic send_end();
    send_item(16'($urandom_range(0, 65535)), 1'b1);
  endtask

  // counting run of candidates
  task automatic send_run(input int base, input int len);
    for (int i = 0; i < len; i++)
      send_item(16'(base + i), 1'b0);
  endtask

  // hold the input low until every pending report is out
  task automatic drain_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  // first primes, composites dropped
  task automatic test_basic_run();
    send_run(2, 11);
    send_end();
  endtask

  // zero prime, prime one, extreme values
  task automatic test_corner_values();
    send_item(16'd0, 1'b0);      // empty stage captures zero
    send_item(16'd1, 1'b0);      // passes zero prime, captured as one
    send_item(16'hFFFF, 1'b0);   // dropped by prime one
    send_item(16'd7, 1'b0);      // dropped by prime one
    send_item(16'hFFFF, 1'b1);   // end marker with ignored number set
    send_item(16'hFFFF, 1'b0);
    send_item(16'd0, 1'b0);      // zero dropped by nonzero prime
    send_item(16'h8000, 1'b0);
    send_item(16'd0, 1'b1);
    send_item(16'd0, 1'b1);      // end marker on an empty chain
  endtask

  // long run that can reach past the last stage, paused midway until drained
  task automatic test_drain_pause();
    int len;
    len = $urandom_range(40, 90);
    send_run(2, len / 2);
    drain_reports();
    send_run(2 + len / 2, len - len / 2);
    send_end();
  endtask

  // mostly well-formed runs, some offset runs and noise
  task automatic test_random_runs();
    int pick;
    int limit;
    limit = sent_items + RANDOM_ITEMS;
    while (sent_items < limit) begin
      if (sent_items > limit - QUIET_TAIL)
        quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 55)
        send_run(2, $urandom_range(5, 80));
      else if (pick < 65)
        send_run(2, $urandom_range(80, 160));
      else if (pick < 80)
        send_run($urandom_range(0, 65535 - 64), $urandom_range(5, 40));
      else if (pick < 95)
        repeat ($urandom_range(1, 20)) send_item(16'($urandom_range(0, 65535)), 1'b0);
      else
        repeat ($urandom_range(1, 3)) send_end();
      // now and then leave the chain filled for the next sequence
      if ($urandom_range(0, 4) != 0)
        send_end();
    end
  endtask

  // output stall in random bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare each accepted report with the oldest prediction
  always @(posedge clk) begin : report_check
    pps_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        note_failure($sformatf("unexpected report kind %0d value %0d stage %0d",
                               out_data.kind, out_data.value, out_data.stage_index));
      end else begin
        want = pending_reports.pop_front();
        if (out_data.kind !== want.kind || out_data.value !== want.value ||
            out_data.stage_index !== want.stage_index)
          note_failure($sformatf("kind %0d/%0d value %0d/%0d stage %0d/%0d (exp/act)",
                                 want.kind, out_data.kind, want.value, out_data.value,
                                 want.stage_index, out_data.stage_index));
      end
    end
  end

  // test sequence
  initial begin
    fail_count = 0;
    sent_items = 0;
    quiet      = 1'b0;
    for (int s = 0; s < pps_pkg::NUM_STAGES; s++) begin
      sieve_prime[s] = '0;
      sieve_full[s]  = 1'b0;
    end
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_run();
    test_corner_values();
    test_drain_pause();
    test_random_runs();

    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/pps_pkg.sv
hdl/pps_cell.sv
hdl/pps_ctrl.sv
hdl/pipelined_prime_sieve.sv
test/tb.sv
